@@ sv/bpfa_pkg.sv @@
// Shared types, constants and the free-bit search for the page frame allocator.
package bpfa_pkg;

	// Bitmap geometry and entry format.
	localparam int WORD_W       = 32;
	localparam int BIT_IDX_W    = 5;
	localparam int WORDS_DEF    = 1024;
	localparam int CFG_W        = 11;
	localparam int FRAME_OUT_W  = 15;
	localparam int FRAME_PTE_W  = 20;
	localparam int IDX_W        = 10;
	localparam logic [10:0] WORDS_RESET = 11'd1024;
	localparam logic [11:0] PTE_FLAGS   = 12'h007;

	typedef enum logic [1:0] {
		STAT_MAPPED  = 2'd0,
		STAT_NEW     = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_NOTABLE = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_MODIFY
	} state_t;

	// Memory port controls handed from the sequencer to the bitmap store.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

	// Index of the lowest clear bit of a word, found by halving five times.
	function automatic logic [BIT_IDX_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
		logic [15:0] v16;
		logic [7:0]  v8;
		logic [3:0]  v4;
		logic [1:0]  v2;
		logic [BIT_IDX_W-1:0] idx;
		idx = '0;
		if (w[15:0] != 16'hFFFF) begin
			v16 = w[15:0];
		end else begin
			v16 = w[31:16];
			idx[4] = 1'b1;
		end
		if (v16[7:0] != 8'hFF) begin
			v8 = v16[7:0];
		end else begin
			v8 = v16[15:8];
			idx[3] = 1'b1;
		end
		if (v8[3:0] != 4'hF) begin
			v4 = v8[3:0];
		end else begin
			v4 = v8[7:4];
			idx[2] = 1'b1;
		end
		if (v4[1:0] != 2'b11) begin
			v2 = v4[1:0];
		end else begin
			v2 = v4[3:2];
			idx[1] = 1'b1;
		end
		idx[0] = v2[0];
		return idx;
	endfunction

endpackage

@@ sv/bpfa_bitmap_mem.sv @@
// Single-port-read, single-port-write bitmap store with registered read data.
module bpfa_bitmap_mem
	import bpfa_pkg::*;
#(
	parameter int DEPTH = WORDS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  mem_ctl_t          ctl,
	input  logic [AW-1:0]     rd_addr,
	input  logic [AW-1:0]     wr_addr,
	input  logic [WORD_W-1:0] wr_data,
	output logic [WORD_W-1:0] rd_data
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/bitmap_page_frame_allocator_unit.sv @@
// Top level of the bitmap page frame allocator: sequencer, result register and bitmap store.
//
//  Channel  Direction  Handshake            Word carried
//  -------  ---------  -------------------  -------------------------------------------------
//  in       sink       in_valid / in_stall  virt_addr, dir_present, pte_present
//  out      source     out_valid/out_stall  status, table_index, entry_index, frame_number,
//                                           pte_value
//  cfg      sink       cfg_valid/cfg_ready  words_in_use
//
// Every request is accepted in the idle state, which reads the current bitmap word from the
// store; the modify state then finds its lowest clear bit, writes the marked word back for a
// fresh allocation and loads the result register; the registered store read forces the split.
// Reset leaves the store untouched; words beyond the scan pointer are known to be free and
// read as zero, so no clearing pass is run and the first request may follow reset at once.
// A result waiting in the output register does not block the next request's read; only the
// write-back cycle waits while the output register is still held by a stalled consumer.
module bitmap_page_frame_allocator_unit
	import bpfa_pkg::*;
#(
	parameter int BITMAP_WORDS = WORDS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Request channel.
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [31:0]            virt_addr,
	input  logic                   dir_present,
	input  logic                   pte_present,
	// Result channel.
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             status,
	output logic [IDX_W-1:0]       table_index,
	output logic [IDX_W-1:0]       entry_index,
	output logic [FRAME_OUT_W-1:0] frame_number,
	output logic [31:0]            pte_value,
	// Configuration channel.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_W-1:0]       words_in_use
);

	// Address width of the store, and width of the scan pointer, which must also be able to
	// hold the depth itself once every word is full.
	localparam int AW   = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
	localparam int PW   = $clog2(BITMAP_WORDS + 1);
	localparam int CW   = (PW > CFG_W) ? PW : CFG_W;
	localparam int FW   = PW + BIT_IDX_W;

	state_t state_q, state_d;

	logic [CFG_W-1:0]  words_in_use_q;
	// The frames are handed out strictly from the bottom, so every word below the pointer is
	// full, and every word above it has never been written.
	logic [PW-1:0]     first_q;
	// Set once the word at the pointer has been written, so its stored value is meaningful.
	logic              word_dirty_q;

	logic [IDX_W-1:0]  tbl_q;
	logic [IDX_W-1:0]  ent_q;
	logic              dir_q;
	logic              pte_q;

	logic              out_valid_q;
	status_t           status_q;
	logic [IDX_W-1:0]  out_tbl_q;
	logic [IDX_W-1:0]  out_ent_q;
	logic [FRAME_OUT_W-1:0] frame_q;
	logic [31:0]       pte_value_q;

	mem_ctl_t          mem_ctl;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] word_eff;
	logic [WORD_W-1:0] word_new;
	logic [BIT_IDX_W-1:0] bit_idx;
	logic [FW-1:0]     frame_full;
	logic              in_accept;
	logic              out_free;
	logic              commit;
	logic              no_room;
	logic              alloc;
	status_t           status_d;

	// No configuration write is refused; the user must write only while idle, as nothing checks it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_in_use_q <= WORDS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			words_in_use_q <= words_in_use;
		end
	end

	// A new request is taken whenever the sequencer is idle, even while a result still waits.
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// The word count saturates at the depth of the store, and a count of zero scans nothing.
	assign no_room = (CW'(first_q) >= CW'(words_in_use_q)) ||
	                 (first_q == PW'(BITMAP_WORDS));

	// Words past the pointer were never written and are free.
	assign word_eff   = word_dirty_q ? rd_data : '0;
	assign bit_idx    = lowest_zero(word_eff);
	assign word_new   = word_eff | (WORD_W'(1) << bit_idx);
	assign frame_full = {first_q, bit_idx};

	always_comb begin
		if (!dir_q) begin
			status_d = STAT_NOTABLE;
		end else if (pte_q) begin
			status_d = STAT_MAPPED;
		end else if (no_room) begin
			status_d = STAT_FULL;
		end else begin
			status_d = STAT_NEW;
		end
	end

	assign alloc = (status_d == STAT_NEW);

	always_comb begin
		state_d = state_q;
		commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_MODIFY;
				end
			end
			ST_MODIFY: begin
				if (out_free) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The word at the pointer is read as the request is accepted; once the pointer has run
	// off the end of the store there is nothing left to read.
	assign mem_ctl.rd_en = in_accept && (first_q != PW'(BITMAP_WORDS));
	assign mem_ctl.wr_en = commit && alloc;

	bpfa_bitmap_mem #(
		.DEPTH (BITMAP_WORDS),
		.AW    (AW)
	) u_bitmap (
		.clk     (clk),
		.ctl     (mem_ctl),
		.rd_addr (first_q[AW-1:0]),
		.wr_addr (first_q[AW-1:0]),
		.wr_data (word_new),
		.rd_data (rd_data)
	);

	// Scan pointer: it moves on when the word it points at has just been filled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q      <= '0;
			word_dirty_q <= 1'b0;
		end else if (mem_ctl.wr_en) begin
			if (word_new == {WORD_W{1'b1}}) begin
				first_q      <= first_q + PW'(1);
				word_dirty_q <= 1'b0;
			end else begin
				word_dirty_q <= 1'b1;
			end
		end
	end

	// Request fields held for the write-back cycle.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			tbl_q <= virt_addr[31:22];
			ent_q <= virt_addr[21:12];
			dir_q <= dir_present;
			pte_q <= pte_present;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Frame fields are zero for every outcome other than a fresh allocation.
	always_ff @(posedge clk) begin
		if (commit) begin
			status_q    <= status_d;
			out_tbl_q   <= tbl_q;
			out_ent_q   <= ent_q;
			frame_q     <= alloc ? FRAME_OUT_W'(frame_full) : '0;
			pte_value_q <= alloc ? {FRAME_PTE_W'(frame_full), PTE_FLAGS} : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign table_index  = out_tbl_q;
	assign entry_index  = out_ent_q;
	assign frame_number = frame_q;
	assign pte_value    = pte_value_q;

	// The scan pointer never runs past the end of the store.
	a_pointer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		first_q <= PW'(BITMAP_WORDS))
		else $error("scan pointer beyond the bitmap");

	// A write-back marks exactly one further frame.
	a_one_bit: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.wr_en |-> ($countones(word_new) == $countones(word_eff) + 1))
		else $error("write-back does not mark exactly one frame");

	// A fresh result only appears after a write-back cycle.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_MODIFY))
		else $error("result raised without a write-back cycle");

	// Reading and writing the store never fall in the same cycle.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_ctl.rd_en && mem_ctl.wr_en))
		else $error("bitmap read and write overlap");

	// The pointer only advances on a write-back.
	a_pointer_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(mem_ctl.wr_en) |-> $stable(first_q))
		else $error("scan pointer moved without an allocation");

endmodule

@@ test/tb_bitmap_page_frame_allocator_unit.sv @@
// Self-checking testbench for the bitmap page frame allocator, with predictor and scoreboard.
`timescale 1ns / 1ps

module tb_bitmap_page_frame_allocator_unit
	import bpfa_pkg::*;
();

	localparam int BITMAP_WORDS   = WORDS_DEF;
	// Quiet cycles before the run is declared hung. The longest honest pause is the forced
	// receiver hold of HOLD_CYCLES plus a few bursts, so this is many times over.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 60;
	// Cycles waited after the last result before checking that nothing is outstanding.
	localparam int SETTLE_CYCLES  = 8;

	// One expected result word, held until the block delivers it.
	typedef struct {
		status_t                status;
		logic [IDX_W-1:0]       table_index;
		logic [IDX_W-1:0]       entry_index;
		logic [FRAME_OUT_W-1:0] frame_number;
		logic [31:0]            pte_value;
	} page_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [31:0]            virt_addr;
	logic                   dir_present;
	logic                   pte_present;
	logic                   out_valid;
	logic                   out_stall;
	logic [1:0]             status;
	logic [IDX_W-1:0]       table_index;
	logic [IDX_W-1:0]       entry_index;
	logic [FRAME_OUT_W-1:0] frame_number;
	logic [31:0]            pte_value;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       words_in_use;

	// The testbench's own copy of the frame bitmap and of the word count register.
	bit [31:0]        frame_map [BITMAP_WORDS];
	logic [CFG_W-1:0] word_count = WORDS_RESET;

	page_result_t pending_results [$];
	int           mismatch_count = 0;
	int           quiet_cycles   = 0;
	int           hold_cycles    = 0;
	bit           gaps_on        = 1'b1;

	bitmap_page_frame_allocator_unit #(
		.BITMAP_WORDS(BITMAP_WORDS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.virt_addr    (virt_addr),
		.dir_present  (dir_present),
		.pte_present  (pte_present),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.table_index  (table_index),
		.entry_index  (entry_index),
		.frame_number (frame_number),
		.pte_value    (pte_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.words_in_use (words_in_use)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the result of one request and updates the bitmap copy. The scan covers the
	// words in use, capped at the size of the array, lowest word and lowest bit first.
	function automatic page_result_t predict_request(input logic [31:0] addr,
			input logic dir, input logic pte);
		page_result_t r;
		int           limit;
		bit           found;
		logic [31:0]  frame;
		r.table_index  = addr[31:22];
		r.entry_index  = addr[21:12];
		r.frame_number = '0;
		r.pte_value    = '0;
		found          = 1'b0;
		frame          = '0;
		if (!dir) begin
			r.status = STAT_NOTABLE;
		end else if (pte) begin
			r.status = STAT_MAPPED;
		end else begin
			limit = (int'(word_count) > BITMAP_WORDS) ? BITMAP_WORDS : int'(word_count);
			for (int w = 0; w < limit && !found; w++) begin
				if (frame_map[w] != 32'hFFFF_FFFF) begin
					for (int b = 0; b < 32 && !found; b++) begin
						if (!frame_map[w][b]) begin
							frame_map[w][b] = 1'b1;
							frame           = w * 32 + b;
							found           = 1'b1;
						end
					end
				end
			end
			if (found) begin
				r.status       = STAT_NEW;
				r.frame_number = frame[FRAME_OUT_W-1:0];
				r.pte_value    = (frame << 12) | 32'(PTE_FLAGS);
			end else begin
				r.status = STAT_FULL;
			end
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Offers one request word and holds it until the block takes it. The expectation is
	// recorded at the accepting edge, so the predictor sees requests in the block's order.
	// Afterwards the sender may go quiet for a short burst, scrambling the idle payload.
	task automatic offer_request(input logic [31:0] addr, input logic dir, input logic pte);
		in_valid    <= 1'b1;
		virt_addr   <= addr;
		dir_present <= dir;
		pte_present <= pte;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(predict_request(addr, dir, pte));
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid    <= 1'b0;
			virt_addr   <= $urandom;
			dir_present <= 1'($urandom);
			pte_present <= 1'($urandom);
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Offers a request with a random address; most ask for a fresh frame, since that is
	// the path that walks the bitmap, and the rest are mapped pages or missing tables.
	task automatic offer_random_request();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			offer_request($urandom, 1'b1, 1'b0);
		end else if (pick < 85) begin
			offer_request($urandom, 1'b1, 1'b1);
		end else begin
			offer_request($urandom, 1'b0, 1'($urandom));
		end
	endtask

	// Stops offering and waits until every expected result word has been delivered.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Writes the word count register once the block has gone idle.
	task automatic set_word_count(input logic [CFG_W-1:0] count);
		wait_for_results();
		cfg_valid    <= 1'b1;
		words_in_use <= count;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid  <= 1'b0;
		word_count  = count;
	endtask

	// Each kind of request at the reset word count, with the address extremes. The low
	// twelve bits of the address must be ignored, and a missing table wins over a present
	// entry.
	task automatic test_request_kinds();
		offer_request(32'h0000_0000, 1'b0, 1'b0);
		offer_request(32'hFFFF_FFFF, 1'b0, 1'b1);
		offer_request(32'hFFFF_F000, 1'b1, 1'b1);
		offer_request(32'h0000_0FFF, 1'b1, 1'b1);
		offer_request(32'h0000_0000, 1'b1, 1'b0);
		offer_request(32'hFFFF_FFFF, 1'b1, 1'b0);
		offer_request(32'h0000_0FFF, 1'b1, 1'b0);
		offer_request(32'hFFC0_0000, 1'b1, 1'b0);
		offer_request(32'h003F_F000, 1'b1, 1'b0);
		offer_request(32'hAAAA_AAAA, 1'b1, 1'b0);
		offer_request(32'h5555_5555, 1'b1, 1'b0);
		offer_request(32'h8000_0000, 1'b0, 1'b1);
		offer_request(32'h7FFF_FFFF, 1'b1, 1'b1);
	endtask

	// A word count of zero scans nothing and must report no free frame; the largest
	// register value must behave as the full array; a count of one confines the scan to
	// the first word.
	task automatic test_word_count_extremes();
		set_word_count(11'd0);
		offer_request(32'h1234_5000, 1'b1, 1'b0);
		offer_request(32'hFEDC_B000, 1'b1, 1'b0);
		offer_request(32'h0040_1000, 1'b1, 1'b1);
		set_word_count(11'd2047);
		offer_request(32'h0000_1000, 1'b1, 1'b0);
		offer_request(32'hFFFF_E000, 1'b1, 1'b0);
		set_word_count(11'd1);
		offer_request(32'h0100_0000, 1'b1, 1'b0);
		offer_request(32'h0200_0000, 1'b1, 1'b0);
		set_word_count(11'd1024);
	endtask

	// The receiver holds off for a long stretch while requests keep coming, so the result
	// register fills and the block must stall its input. Then the sender pauses until
	// everything outstanding has arrived before it carries on.
	task automatic test_output_backpressure();
		hold_cycles = HOLD_CYCLES;
		repeat (24) offer_request($urandom, 1'b1, 1'b0);
		wait_for_results();
		repeat (10) offer_random_request();
	endtask

	// Random traffic in phases, each at its own word count. Small counts run the first
	// words full so that exhaustion is seen often; the last phase runs with no idling.
	task automatic test_random_traffic();
		logic [CFG_W-1:0] count;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					count = 11'd1;
				end
				1: begin
					count = 11'd1024;
				end
				2: begin
					count = CFG_W'($urandom_range(2, 12));
				end
				3: begin
					count = 11'd2047;
				end
				4: begin
					count = CFG_W'($urandom_range(1, 1024));
				end
				5: begin
					count = CFG_W'($urandom_range(10, 20));
				end
				6: begin
					count = CFG_W'($urandom_range(2, 24));
				end
				default: begin
					count = 11'd1024;
				end
			endcase
			set_word_count(count);
			if (phase == 7) begin
				gaps_on = 1'b0;
			end
			repeat (100) offer_random_request();
		end
	endtask

	// Receiver side: a forced hold when a test asks for one, otherwise short random bursts
	// of stall. Exactly one assignment to the stall line is made at each edge.
	initial begin : receiver_stalls
		int burst_left;
		out_stall  = 1'b0;
		burst_left = 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (burst_left > 0) begin
				out_stall <= 1'b1;
				burst_left--;
			end else if (gaps_on && arst_n && $urandom_range(0, 5) == 0) begin
				out_stall  <= 1'b1;
				burst_left  = $urandom_range(0, 3);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Every result word taken by the receiver is matched against the oldest expectation.
	always @(posedge clk) begin
		page_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result word, status %0d", status));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					flag_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
				end
				if (table_index !== want.table_index) begin
					flag_mismatch($sformatf("table_index %0d, wanted %0d",
						table_index, want.table_index));
				end
				if (entry_index !== want.entry_index) begin
					flag_mismatch($sformatf("entry_index %0d, wanted %0d",
						entry_index, want.entry_index));
				end
				if (frame_number !== want.frame_number) begin
					flag_mismatch($sformatf("frame_number %0d, wanted %0d",
						frame_number, want.frame_number));
				end
				if (pte_value !== want.pte_value) begin
					flag_mismatch($sformatf("pte_value %h, wanted %h",
						pte_value, want.pte_value));
				end
			end
		end
	end

	// A run in which no word moves on any channel for too long has hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		virt_addr    = '0;
		dir_present  = 1'b0;
		pte_present  = 1'b0;
		cfg_valid    = 1'b0;
		words_in_use = WORDS_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_request_kinds();
		test_word_count_extremes();
		test_output_backpressure();
		test_random_traffic();

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			flag_mismatch($sformatf("%0d result words never arrived", pending_results.size()));
		end
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/bpfa_pkg.sv
sv/bpfa_bitmap_mem.sv
sv/bitmap_page_frame_allocator_unit.sv
test/tb_bitmap_page_frame_allocator_unit.sv
